### rtl/core/bpc_pkg.sv
// Shared widths, constants, register indexes and types of the pressure compensation core.
package bpc_pkg;

  // Field widths of the requests and results.
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int PRESS_W = 32;
  localparam int TEMP_W  = 19;

  // Configuration port index width and register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

  // Number of register stages from request to result, and an occupancy counter width.
  localparam int PIPE_DEPTH = 9;
  localparam int OCC_W      = 4;

  // Temperature pivots of the second-order correction, in 0.01 degC.
  localparam logic signed [TEMP_W-1:0] T_PIVOT    = 19'sd2000;
  localparam logic signed [TEMP_W:0]   T_PIVOT_X  = 20'sd2000;
  localparam logic signed [TEMP_W:0]   T_COLD_NEG = 20'sd1500;

  // Factory calibration words.
  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

endpackage

### rtl/core/bpc_in_if.sv
// Request channel carrying one raw pressure and temperature conversion pair.
interface bpc_in_if import bpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

### rtl/core/bpc_out_if.sv
// Result channel carrying compensated pressure and temperature.
interface bpc_out_if import bpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PRESS_W-1:0] pressure_centi_mbar;
  logic signed [TEMP_W-1:0]  temperature_centi_deg;

  modport source (output valid, output pressure_centi_mbar, output temperature_centi_deg,
                  input ready);
  modport sink   (input valid, input pressure_centi_mbar, input temperature_centi_deg,
                  output ready);
endinterface

### rtl/core/baro_pressure_temp_compensation_core.sv
// A request passes through stage registers s0 to s8 to its result on the output register.
// Throughput: one request per cycle while any stage has room; each stage holds its own
// valid bit, so a stalled result only blocks the stages behind it once they are all full.
// The widest step is the 24 x 40 bit pressure product, split into two 24 x 20 halves.
// Reset (synchronous, active high) clears all valid bits and sets C1 to C6 to zero.
module baro_pressure_temp_compensation_core import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wr_data,
  bpc_in_if.sink               sample,
  bpc_out_if.source            result
);

  cal_t cal;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH:0]   en;

  // Stage registers.
  logic signed [RAW_W:0]  s0_dt;
  logic [RAW_W-1:0]       s0_d1, s1_d1, s2_d1, s3_d1, s4_d1, s5_d1;
  logic signed [41:0]     s1_pt, s1_poff, s1_psens;
  logic signed [49:0]     s1_pdt2;
  logic signed [TEMP_W-1:0] s2_temp, s3_temp, s4_temp, s5_temp, s6_temp, s7_temp;
  logic signed [TEMP_W-1:0] s2_t2, s3_t2, s4_t2;
  logic signed [39:0]     s2_off, s3_off, s4_off, s5_off, s6_off, s7_off;
  logic signed [39:0]     s2_sens, s3_sens, s4_sens, s5_sens;
  logic signed [39:0]     s3_a, s3_b;
  logic                   s3_cold, s3_vcold, s4_cold;
  logic signed [39:0]     s4_off2, s4_sens2;
  logic [43:0]            s6_pl;
  logic signed [44:0]     s6_ph;
  logic signed [43:0]     s7_x;
  logic signed [PRESS_W-1:0] s8_press;
  logic signed [TEMP_W-1:0]  s8_temp;

  // Combinational values between stages.
  logic signed [RAW_W:0]    dt_next;
  logic signed [CAL_W:0]    c3s, c4s, c6s;
  logic signed [41:0]       pt_next, poff_next, psens_next;
  logic signed [49:0]       pdt2_next;
  logic signed [TEMP_W-1:0] temp_next, t2_next;
  logic signed [39:0]       off_next, sens_next;
  logic signed [TEMP_W:0]   da, db;
  logic signed [39:0]       a_next, b_next;
  logic signed [39:0]       a_half, a_quart, b_half;
  logic signed [39:0]       off2_next, sens2_next;
  logic signed [39:0]       offc_next, sensc_next;
  logic signed [TEMP_W-1:0] tempc_next;
  logic [43:0]              pl_next;
  logic signed [44:0]       ph_next;
  logic signed [64:0]       prod_sum;
  logic signed [47:0]       press_diff;

  // Calibration register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_C1:  cal.c1 <= cfg_wr_data;
        REG_C2:  cal.c2 <= cfg_wr_data;
        REG_C3:  cal.c3 <= cfg_wr_data;
        REG_C4:  cal.c4 <= cfg_wr_data;
        REG_C5:  cal.c5 <= cfg_wr_data;
        REG_C6:  cal.c6 <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads too.
  always_comb begin
    en[PIPE_DEPTH] = result.ready;
    for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign sample.ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample.valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: temperature difference to the reference.
  assign dt_next = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dt <= dt_next;
      s0_d1 <= sample.raw_pressure;
    end
  end

  // Stage 1: first-order products of dT.
  assign c3s        = $signed({1'b0, cal.c3});
  assign c4s        = $signed({1'b0, cal.c4});
  assign c6s        = $signed({1'b0, cal.c6});
  assign pt_next    = s0_dt * c6s;
  assign poff_next  = s0_dt * c4s;
  assign psens_next = s0_dt * c3s;
  assign pdt2_next  = s0_dt * s0_dt;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pt    <= pt_next;
      s1_poff  <= poff_next;
      s1_psens <= psens_next;
      s1_pdt2  <= pdt2_next;
      s1_d1    <= s0_d1;
    end
  end

  // Stage 2: first-order temperature, offset and sensitivity; the shifts floor.
  assign temp_next = $signed(s1_pt[41:23]) + T_PIVOT;
  assign off_next  = $signed({8'h00, cal.c2, 16'h0000})
                   + $signed({{5{s1_poff[41]}}, s1_poff[41:7]});
  assign sens_next = $signed({9'h000, cal.c1, 15'h0000})
                   + $signed({{6{s1_psens[41]}}, s1_psens[41:8]});
  assign t2_next   = $signed(s1_pdt2[49:31]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_temp <= temp_next;
      s2_off  <= off_next;
      s2_sens <= sens_next;
      s2_t2   <= t2_next;
      s2_d1   <= s1_d1;
    end
  end

  // Stage 3: squared distances from both pivots; their signs flag the cold ranges.
  assign da     = $signed({s2_temp[TEMP_W-1], s2_temp}) - T_PIVOT_X;
  assign db     = $signed({s2_temp[TEMP_W-1], s2_temp}) + T_COLD_NEG;
  assign a_next = da * da;
  assign b_next = db * db;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_a     <= a_next;
      s3_b     <= b_next;
      s3_cold  <= da[TEMP_W];
      s3_vcold <= db[TEMP_W];
      s3_temp  <= s2_temp;
      s3_off   <= s2_off;
      s3_sens  <= s2_sens;
      s3_t2    <= s2_t2;
      s3_d1    <= s2_d1;
    end
  end

  // Stage 4: second-order offset and sensitivity corrections, zero when warm.
  assign a_half  = s3_a >>> 1;
  assign a_quart = s3_a >>> 2;
  assign b_half  = s3_b >>> 1;

  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    if (s3_cold) begin
      off2_next  = a_half * 40'sd5;
      sens2_next = a_quart * 40'sd5;
      if (s3_vcold) begin
        off2_next  = a_half * 40'sd5 + s3_b * 40'sd7;
        sens2_next = a_quart * 40'sd5 + b_half * 40'sd11;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_off2  <= off2_next;
      s4_sens2 <= sens2_next;
      s4_cold  <= s3_cold;
      s4_temp  <= s3_temp;
      s4_t2    <= s3_t2;
      s4_off   <= s3_off;
      s4_sens  <= s3_sens;
      s4_d1    <= s3_d1;
    end
  end

  // Stage 5: apply the corrections.
  assign offc_next  = s4_off - s4_off2;
  assign sensc_next = s4_sens - s4_sens2;
  assign tempc_next = s4_cold ? (s4_temp - s4_t2) : s4_temp;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_off  <= offc_next;
      s5_sens <= sensc_next;
      s5_temp <= tempc_next;
      s5_d1   <= s4_d1;
    end
  end

  // Stage 6: D1 times SENS as two partial products over the low and high sensitivity halves.
  assign pl_next = s5_d1 * s5_sens[19:0];
  assign ph_next = $signed({1'b0, s5_d1}) * $signed(s5_sens[39:20]);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pl   <= pl_next;
      s6_ph   <= ph_next;
      s6_off  <= s5_off;
      s6_temp <= s5_temp;
    end
  end

  // Stage 7: merge the partial products and scale down by 2^21.
  assign prod_sum = $signed({s6_ph, 20'h00000}) + $signed({21'h000000, s6_pl});

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_x    <= $signed(prod_sum[64:21]);
      s7_off  <= s6_off;
      s7_temp <= s6_temp;
    end
  end

  // Stage 8: remove the offset and scale down by 2^15 into the output register.
  assign press_diff = $signed({{4{s7_x[43]}}, s7_x}) - $signed({{8{s7_off[39]}}, s7_off});

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_press <= $signed(press_diff[46:15]);
      s8_temp  <= s7_temp;
    end
  end

  assign result.valid                 = vld[PIPE_DEPTH-1];
  assign result.pressure_centi_mbar   = s8_press;
  assign result.temperature_centi_deg = s8_temp;

endmodule

### rtl/core/bpc_checker.sv
// Port-level checker for the pressure compensation core, bound to its top level.
module bpc_checker import bpc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [PRESS_W-1:0] pressure,
  input logic signed [TEMP_W-1:0]  temperature
);

  logic [OCC_W-1:0] inflight;
  logic             in_fire;
  logic             out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count requests that have entered but whose results are not yet taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_fire && !out_fire) begin
      inflight <= inflight + 1'b1;
    end else if (out_fire && !in_fire) begin
      inflight <= inflight - 1'b1;
    end
  end

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pressure) && $stable(temperature)))
    else $error("result changed while stalled");

  // Requests are refused only when every stage is full and the result is stalled.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (inflight == OCC_W'(PIPE_DEPTH)) && !out_ready)
    else $error("request refused while the pipeline had room");

  // No result appears without a request behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inflight != '0))
    else $error("result shown with no request in flight");

  // The pipeline never holds more requests than it has stages.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    inflight <= OCC_W'(PIPE_DEPTH))
    else $error("more requests in flight than stages");

endmodule

bind baro_pressure_temp_compensation_core bpc_checker u_bpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .pressure    (result.pressure_centi_mbar),
  .temperature (result.temperature_centi_deg)
);
